[rtl/cmi_pkg.sv]
// ----------------------------------------------------------------------------
// cmi_pkg: shared constants for the complex magnitude square root block
// Default sizes and the fixed width of the magnitude field.
// ----------------------------------------------------------------------------
`default_nettype none

package cmi_pkg;

   // default sample width of each part
   localparam int SAMPLE_WIDTH_DEF = 16;
   // default number of root trials
   localparam int ROOT_BITS_DEF    = 16;
   // magnitude field width on the result channel
   localparam int MAG_WIDTH        = 16;

   // input bus width: two parts, padded to whole bytes
   function automatic int req_data_width(input int sample_width);
      return ((2 * sample_width + 7) / 8) * 8;
   endfunction

endpackage : cmi_pkg

`default_nettype wire

[rtl/complex_magnitude_isqrt.sv]
// ----------------------------------------------------------------------------
// complex_magnitude_isqrt: floor(sqrt(re^2 + im^2)) of a complex sample
// Pipelined magnitude unit: abs, square, sum, then one root trial per stage.
// ----------------------------------------------------------------------------
// Stages: the three front stages plus one register stage per root trial lie
//   between the req transfer and rsp_tvalid.
// Throughput: one sample per cycle unless all stages are full and rsp is held;
//   a stage with a held successor still takes a new sample while a bubble lies ahead.
// Reset: synchronous; clears every stage valid bit, payload is not reset.
`default_nettype none

module complex_magnitude_isqrt #(
   parameter int SAMPLE_WIDTH = cmi_pkg::SAMPLE_WIDTH_DEF,
   parameter int ROOT_BITS    = cmi_pkg::ROOT_BITS_DEF
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   // request channel
   input  wire logic                                             req_tvalid,
   output logic                                                  req_tready,
   // fields from bit 0: real_part, imag_part, zero pad
   input  wire logic [cmi_pkg::req_data_width(SAMPLE_WIDTH)-1:0] req_tdata,
   // response channel
   output logic                                                  rsp_tvalid,
   input  wire logic                                             rsp_tready,
   // fields from bit 0: magnitude
   output logic [cmi_pkg::MAG_WIDTH-1:0]                         rsp_tdata
);

   import cmi_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int SUM_W  = 2 * SAMPLE_WIDTH;
   localparam int SQ_W   = (2 * ROOT_BITS > SUM_W) ? 2 * ROOT_BITS : SUM_W;
   // abs, square, sum, then one stage per trial
   localparam int NSTAGE = ROOT_BITS + 3;

   // stage valid bits and stage load enables
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] full_tail;
   logic [NSTAGE-1:0] stg_rdy;

   // front stages
   logic [SW-1:0]    re_raw;
   logic [SW-1:0]    im_raw;
   logic [SW-1:0]    re_abs_ff;
   logic [SW-1:0]    im_abs_ff;
   logic [SW-1:0]    re_abs_in;
   logic [SW-1:0]    im_abs_in;
   logic [SUM_W-1:0] re_sq_ff;
   logic [SUM_W-1:0] im_sq_ff;

   // trial stages: index 0 holds the sum, index t the state after trial t
   logic [SUM_W-1:0]     sum_ff  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0] cand_ff [ROOT_BITS+1];
   logic [SQ_W-1:0]      sq_ff   [ROOT_BITS+1];

   // a stage may load when the response is taken or a bubble lies at or after it
   always_comb begin
      full_tail[NSTAGE-1] = vld_ff[NSTAGE-1];
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         full_tail[i] = vld_ff[i] & full_tail[i+1];
      end
      stg_rdy = ~full_tail | {NSTAGE{rsp_tready}};
   end

   // valid bits move along with the data
   always_comb begin
      vld_in = vld_ff;
      for (int i = 0; i < NSTAGE; i++) begin
         if (stg_rdy[i]) begin
            vld_in[i] = (i == 0) ? req_tvalid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // absolute value of each part, taken from its low sample bits
   assign re_raw    = req_tdata[SW-1:0];
   assign im_raw    = req_tdata[2*SW-1:SW];
   assign re_abs_in = re_raw[SW-1] ? SW'(-re_raw) : re_raw;
   assign im_abs_in = im_raw[SW-1] ? SW'(-im_raw) : im_raw;

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         re_abs_ff <= re_abs_in;
         im_abs_ff <= im_abs_in;
      end
   end

   // one multiplier per part
   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         re_sq_ff <= SUM_W'(re_abs_ff) * SUM_W'(re_abs_ff);
         im_sq_ff <= SUM_W'(im_abs_ff) * SUM_W'(im_abs_ff);
      end
   end

   // sum of squares, root candidate cleared
   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         sum_ff[0]  <= re_sq_ff + im_sq_ff;
         cand_ff[0] <= '0;
         sq_ff[0]   <= '0;
      end
   end

   // one trial per stage, from the top root bit down; the square is kept
   // incrementally: (c + 2^k)^2 = c^2 + c*2^(k+1) + 2^(2k)
   for (genvar t = 1; t <= ROOT_BITS; t++) begin : g_trial
      localparam int K = ROOT_BITS - t;

      logic [ROOT_BITS-1:0] trial;
      logic [SQ_W-1:0]      trial_sq;
      logic                 keep;

      assign trial    = cand_ff[t-1] | (ROOT_BITS'(1) << K);
      assign trial_sq = sq_ff[t-1] + (SQ_W'(cand_ff[t-1]) << (K + 1))
                        + (SQ_W'(1) << (2 * K));
      assign keep     = trial_sq <= SQ_W'(sum_ff[t-1]);

      always_ff @(posedge clock) begin
         if (stg_rdy[t+2]) begin
            sum_ff[t]  <= sum_ff[t-1];
            cand_ff[t] <= keep ? trial : cand_ff[t-1];
            sq_ff[t]   <= keep ? trial_sq : sq_ff[t-1];
         end
      end
   end

   // handshake and result
   assign req_tready = stg_rdy[0];
   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = MAG_WIDTH'(cand_ff[ROOT_BITS]);

endmodule : complex_magnitude_isqrt

`default_nettype wire

[rtl/cmi_checker.sv]
// ----------------------------------------------------------------------------
// cmi_checker: port-level checks for complex_magnitude_isqrt
// Watches the two stream channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cmi_checker #(
   parameter int REQ_W = cmi_pkg::req_data_width(cmi_pkg::SAMPLE_WIDTH_DEF)
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   // fields from bit 0: real_part, imag_part, zero pad
   input wire logic [REQ_W-1:0]              req_tdata,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   // fields from bit 0: magnitude
   input wire logic [cmi_pkg::MAG_WIDTH-1:0] rsp_tdata
);

   import cmi_pkg::*;

   // a held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // nothing comes out straight after reset
   a_rst_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // an empty output stage means the pipeline has room
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   // a taken result frees a place for the next sample
   a_flow_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp ready");

endmodule : cmi_checker

bind complex_magnitude_isqrt cmi_checker #(
   .REQ_W(cmi_pkg::req_data_width(SAMPLE_WIDTH))
) u_cmi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stream-level check of complex_magnitude_isqrt
// Drives complex samples over the req channel with random idle gaps and
// back-pressure on rsp, predicts each magnitude independently and checks the
// response stream in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW          = cmi_pkg::SAMPLE_WIDTH_DEF;
   localparam int TRIALS      = cmi_pkg::ROOT_BITS_DEF;
   localparam int REQ_W       = cmi_pkg::req_data_width(SW);
   localparam int MAG_W       = cmi_pkg::MAG_WIDTH;
   localparam int LATENCY     = TRIALS + 3;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX  = 10;

   // In-order scoreboard of expected magnitudes
   class magnitude_board;
      logic [MAG_W-1:0] magnitudes_due[$];
      int failures;

      // floor(sqrt(re^2 + im^2)) built one root bit per trial, top bit first
      static function logic [MAG_W-1:0] magnitude_of(logic [SW-1:0] re, logic [SW-1:0] im);
         logic [63:0] abs_re, abs_im, sum_sq, root, trial;
         abs_re = re[SW-1] ? (64'd1 << SW) - 64'(re) : 64'(re);
         abs_im = im[SW-1] ? (64'd1 << SW) - 64'(im) : 64'(im);
         sum_sq = abs_re * abs_re + abs_im * abs_im;
         root   = '0;
         for (int k = TRIALS - 1; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= sum_sq) begin
               root = trial;
            end
         end
         return root[MAG_W-1:0];
      endfunction

      function void flag(string msg);
         if (failures < REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
         end
         failures++;
      endfunction

      // accepted sample: queue its magnitude
      function void note_sample(logic [SW-1:0] re, logic [SW-1:0] im);
         magnitudes_due.push_back(magnitude_of(re, im));
      endfunction

      // accepted response: compare with the oldest expectation
      function void check_magnitude(logic [MAG_W-1:0] got);
         logic [MAG_W-1:0] want;
         if (magnitudes_due.size() == 0) begin
            flag($sformatf("unexpected magnitude %0d with nothing outstanding", got));
         end else begin
            want = magnitudes_due.pop_front();
            if (got !== want) begin
               flag($sformatf("magnitude mismatch: expected %0d, got %0d", want, got));
            end
         end
      endfunction

      function int pending();
         return magnitudes_due.size();
      endfunction

      function bit passed();
         if (magnitudes_due.size() != 0) begin
            flag($sformatf("%0d magnitudes never arrived", magnitudes_due.size()));
         end
         return failures == 0;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // real_part, imag_part
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [MAG_W-1:0] rsp_tdata;   // magnitude

   magnitude_board board = new();
   bit             calm;          // both sides run without idling
   bit             long_hold_req; // asks the receiver for a long hold-off
   int unsigned    cycles;

   complex_magnitude_isqrt #(
      .SAMPLE_WIDTH (SW),
      .ROOT_BITS    (TRIALS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Transfers seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_sample(req_tdata[SW-1:0], req_tdata[2*SW-1:SW]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_magnitude(rsp_tdata);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random stalls, a long hold-off on request, calm stretches
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            stall_left    = 400;
            long_hold_req = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) begin
               stall_left = idle_len() + 1;
            end
         end
      end
   end

   // One sample transfer after an idle gap; valid stays up for back-to-back
   task automatic send_sample(input logic [SW-1:0] re, input logic [SW-1:0] im,
                              input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait for every outstanding magnitude
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= REQ_W'($urandom);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Random sample part: full range, small, or near the extremes
   function automatic logic [SW-1:0] random_part();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return SW'($urandom);
      if (r < 80) return SW'($urandom_range(0, 32)) - SW'(16);
      if ($urandom_range(0, 1)) return SW'(16'h8000 + $urandom_range(0, 7));
      return SW'(16'h7FFF - $urandom_range(0, 7));
   endfunction

   // Stimulus
   initial begin
      logic [SW-1:0] corner_re[$];
      logic [SW-1:0] corner_im[$];
      int gap;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      long_hold_req = 1'b0;
      cycles     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners: zero, both extremes per part, both parts most
      // negative (largest sum), sign mix, unit values, a Pythagorean triple
      corner_re = '{16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000,
                    16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'hFFFF,
                    16'h0003, 16'hFFFD, 16'h5555, 16'hAAAA, 16'h00FF, 16'h0064,
                    16'h8001, 16'h0000};
      corner_im = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000,
                    16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000,
                    16'h0004, 16'hFFFC, 16'hAAAA, 16'h5555, 16'h00FF, 16'h0000,
                    16'h8001, 16'h0001};
      foreach (corner_re[i]) begin
         send_sample(corner_re[i], corner_im[i], 0);
      end
      // sender pauses until every result is back
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long receiver hold-off while the sender keeps offering
         if (n == 300) long_hold_req = 1'b1;
         calm = (n >= 600 && n < 800);
         if (n == 1000) drain();
         gap = (calm || (n >= 300 && n < 420)) ? 0 : idle_len();
         send_sample(random_part(), random_part(), gap);
      end

      drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (board.passed()) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/cmi_pkg.sv
rtl/complex_magnitude_isqrt.sv
rtl/cmi_checker.sv
sim/testbench.sv
